FILE: hdl/tcle_pkg.sv
package tcle_pkg;

  // Character codes that the editor reacts to.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_BS     = 8'h08;

  // Request queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  typedef struct packed {
    logic [7:0] char_in;
    logic       final_char;
  } in_req_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       run_end;
    logic       text_empty;
    logic       overflowed;
  } out_res_t;

  // Buffer operation that the back part carries out for one request.
  typedef enum logic [2:0] {
    OP_PUT    = 3'd0,
    OP_CR     = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_BS_DEL = 3'd3,
    OP_BS_PUT = 3'd4
  } edit_op_t;

  typedef struct packed {
    logic       pre_bslash;
    edit_op_t   op;
    logic [7:0] ch;
    logic       fin;
  } edit_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

FILE: hdl/text_control_char_line_editor.sv
// Character line editor. Raise start with one character on in_data; the request is taken
// at a clock edge where busy is low. Requests flow into a four-entry queue, so busy rises
// only when that queue is full. The back part handles an ordinary character in its op
// state, passes a pre state first when a broken backslash escape must be stored, and a
// carriage return spends a read state and a check state on every character it walks
// back over on its way to the previous newline, since the text buffer read is registered.
// On a request marked final the buffer is sent out one character per cycle, or a single
// result flagged text_empty when nothing is stored. Each result is shown on out_data for
// exactly one cycle while out_valid is high, and the receiver cannot stall it. The escape
// enable register is written through cfg_valid/cfg_data and comes out of reset set; write
// it only while no request is in flight.
module text_control_char_line_editor import tcle_pkg::*; #(
  parameter int BUF_DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_data,
  output logic     out_valid,
  output out_res_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  logic      esc_en_r, esc_en_nxt;
  logic      push;
  logic      pop;
  edit_req_t push_data;
  edit_req_t head;
  q_status_t q_stat;

  // The single configuration register is always ready to be written.
  assign cfg_ready  = 1'b1;
  assign esc_en_nxt = (cfg_valid && cfg_ready) ? cfg_data : esc_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_en_r <= 1'b1;
    end else begin
      esc_en_r <= esc_en_nxt;
    end
  end

  // The front part resolves escapes and classifies each character into a buffer
  // operation, so the back part never has to look at raw input history.
  tcle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .esc_en    (esc_en_r),
    .q_stat    (q_stat),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  tcle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // The back part owns the text buffer, the carriage return walk and the output run.
  tcle_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // An empty-buffer result is always the whole run.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.text_empty |-> out_data.run_end)
    else $error("empty result not marked as end of run");

  // A new run needs a fresh request to be executed, so runs never abut.
  a_run_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_end |=> !out_valid)
    else $error("result strobe directly after end of run");

  // The back part only takes a request that is really in the queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

endmodule

FILE: hdl/tcle_front.sv
module tcle_front import tcle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_req_t   in_data,
  input  logic      esc_en,
  input  q_status_t q_stat,
  output logic      busy,
  output logic      push,
  output edit_req_t push_data
);

  logic       esc_pend_r, esc_pend_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic       seen_r, seen_nxt;
  logic       accept;
  edit_op_t   cls_op;
  logic [7:0] c;
  logic       fin;

  assign c      = in_data.char_in;
  assign fin    = in_data.final_char;
  assign busy   = q_stat.full;
  assign accept = start && !busy;

  // Plain classification of a raw character into a buffer operation.
  always_comb begin
    if (c == CH_CR) begin
      cls_op = OP_CR;
    end else if (c == CH_FF) begin
      cls_op = fin ? OP_PUT : OP_CLEAR;
    end else if (c == CH_BS) begin
      cls_op = (seen_r && prev_r != CH_LF) ? OP_BS_DEL : OP_BS_PUT;
    end else begin
      cls_op = OP_PUT;
    end
  end

  always_comb begin
    push_data = '{pre_bslash: 1'b0, op: cls_op, ch: c, fin: fin};
    push      = accept;
    if (esc_pend_r) begin
      if (c == CH_BSLASH) begin
        push_data.op = OP_PUT;
        push_data.ch = CH_BSLASH;
      end else if (c == CH_N) begin
        push_data.op = OP_PUT;
        push_data.ch = CH_LF;
      end else begin
        push_data.pre_bslash = 1'b1;
      end
    end else if (esc_en && c == CH_BSLASH && !fin) begin
      push = 1'b0;
    end
  end

  always_comb begin
    esc_pend_nxt = esc_pend_r;
    prev_nxt     = prev_r;
    seen_nxt     = seen_r;
    if (accept) begin
      if (fin) begin
        esc_pend_nxt = 1'b0;
        prev_nxt     = '0;
        seen_nxt     = 1'b0;
      end else begin
        esc_pend_nxt = !esc_pend_r && esc_en && c == CH_BSLASH;
        prev_nxt     = c;
        seen_nxt     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_pend_r <= 1'b0;
      prev_r     <= '0;
      seen_r     <= 1'b0;
    end else begin
      esc_pend_r <= esc_pend_nxt;
      prev_r     <= prev_nxt;
      seen_r     <= seen_nxt;
    end
  end

endmodule

FILE: hdl/tcle_queue.sv
module tcle_queue import tcle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  edit_req_t push_data,
  input  logic      pop,
  output edit_req_t head,
  output q_status_t q_stat
);

  edit_req_t            slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0]  count_r, count_nxt;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == QUEUE_CW'(QUEUE_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + QUEUE_CW'(push) - QUEUE_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: hdl/tcle_back.sv
module tcle_back import tcle_pkg::*; #(
  parameter int BUF_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_stat,
  input  edit_req_t head,
  output logic      pop,
  output logic      out_valid,
  output out_res_t  out_data
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int LW = $clog2(BUF_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PRE    = 6'b000010,
    S_OP     = 6'b000100,
    S_CR_RD  = 6'b001000,
    S_CR_CHK = 6'b010000,
    S_EMIT   = 6'b100000
  } back_state_t;

  back_state_t   state_r, state_nxt;
  edit_req_t     cur_r, cur_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] walk_r, walk_nxt;
  logic [LW-1:0] walk_dec;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          ovf_r, ovf_nxt;
  logic          full;

  logic [7:0]    buf_mem [BUF_DEPTH];
  logic [7:0]    rdata_r;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [7:0]    wd;

  logic          rd_v_r, rd_v_nxt;
  logic          rd_last_r, rd_last_nxt;
  logic          rd_empty_r, rd_empty_nxt;
  logic          rd_ovf_r, rd_ovf_nxt;

  assign full     = (len_r == LW'(BUF_DEPTH));
  assign walk_dec = walk_r - LW'(1);

  assign out_valid = rd_v_r;
  assign out_data  = '{char_out:   rd_empty_r ? 8'd0 : rdata_r,
                       run_end:    rd_last_r,
                       text_empty: rd_empty_r,
                       overflowed: rd_ovf_r};

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    len_nxt      = len_r;
    walk_nxt     = walk_r;
    idx_nxt      = idx_r;
    ovf_nxt      = ovf_r;
    pop          = 1'b0;
    we           = 1'b0;
    wa           = len_r[AW-1:0];
    wd           = cur_r.ch;
    ra           = idx_r;
    rd_v_nxt     = 1'b0;
    rd_last_nxt  = 1'b0;
    rd_empty_nxt = 1'b0;
    rd_ovf_nxt   = ovf_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          cur_nxt   = head;
          state_nxt = head.pre_bslash ? S_PRE : S_OP;
        end
      end
      S_PRE: begin
        // Backslash left over from an escape that did not complete.
        wd = CH_BSLASH;
        if (full) begin
          ovf_nxt = 1'b1;
        end else begin
          we      = 1'b1;
          len_nxt = len_r + LW'(1);
        end
        state_nxt = S_OP;
      end
      S_OP: begin
        case (cur_r.op)
          OP_PUT: begin
            if (full) begin
              ovf_nxt = 1'b1;
            end else begin
              we      = 1'b1;
              len_nxt = len_r + LW'(1);
            end
          end
          OP_BS_PUT: begin
            if (len_r != '0) begin
              if (full) begin
                ovf_nxt = 1'b1;
              end else begin
                we      = 1'b1;
                len_nxt = len_r + LW'(1);
              end
            end
          end
          OP_BS_DEL: begin
            if (len_r != '0) begin
              len_nxt = len_r - LW'(1);
            end
          end
          OP_CLEAR: begin
            len_nxt = '0;
          end
          OP_CR: begin
            walk_nxt = len_r;
          end
          default: begin
          end
        endcase
        if (cur_r.op == OP_CR) begin
          state_nxt = S_CR_RD;
        end else begin
          state_nxt = cur_r.fin ? S_EMIT : S_IDLE;
        end
      end
      S_CR_RD: begin
        if (walk_r == '0) begin
          len_nxt   = '0;
          state_nxt = cur_r.fin ? S_EMIT : S_IDLE;
        end else begin
          ra        = walk_dec[AW-1:0];
          state_nxt = S_CR_CHK;
        end
      end
      S_CR_CHK: begin
        if (rdata_r == CH_LF) begin
          len_nxt   = walk_r;
          state_nxt = cur_r.fin ? S_EMIT : S_IDLE;
        end else begin
          walk_nxt  = walk_dec;
          state_nxt = S_CR_RD;
        end
      end
      S_EMIT: begin
        rd_v_nxt = 1'b1;
        if (len_r == '0) begin
          rd_last_nxt  = 1'b1;
          rd_empty_nxt = 1'b1;
          ovf_nxt      = 1'b0;
          idx_nxt      = '0;
          state_nxt    = S_IDLE;
        end else begin
          ra          = idx_r;
          rd_last_nxt = (LW'(idx_r) + LW'(1) == len_r);
          if (rd_last_nxt) begin
            len_nxt   = '0;
            ovf_nxt   = 1'b0;
            idx_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      buf_mem[wa] <= wd;
    end
    rdata_r <= buf_mem[ra];
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    walk_r     <= walk_nxt;
    rd_last_r  <= rd_last_nxt;
    rd_empty_r <= rd_empty_nxt;
    rd_ovf_r   <= rd_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      idx_r   <= '0;
      ovf_r   <= 1'b0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      ovf_r   <= ovf_nxt;
      rd_v_r  <= rd_v_nxt;
    end
  end

endmodule

FILE: tb/text_control_char_line_editor_tb.sv
module text_control_char_line_editor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcle_pkg::*;

  localparam int BUF_DEPTH = 64;

  // Cycles that the editor may still need once the last expected result has
  // arrived. A carriage return walks back over up to a full buffer, one read
  // per character, and up to four requests can sit in its queue.
  localparam int SETTLE_CYCLES = 600;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     start     = 1'b0;
  in_req_t  in_data   = '0;
  logic     cfg_valid = 1'b0;
  logic     cfg_data  = 1'b0;
  logic     busy;
  logic     out_valid;
  out_res_t out_data;
  logic     cfg_ready;

  always #2 clk = ~clk;

  text_control_char_line_editor #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Our own image of the editor: the text buffer, the editing state that
  // carries from one character to the next, and the escape enable register.
  logic [7:0]  text_img [BUF_DEPTH];
  int unsigned text_len  = 0;
  bit          esc_wait  = 1'b0;
  logic [7:0]  last_raw  = 8'h00;
  bit          got_first = 1'b0;
  bit          dropped   = 1'b0;
  bit          esc_on    = 1'b1;

  // Characters of the edited text that the editor still owes us, oldest first.
  out_res_t    expected_text[$];
  int unsigned mismatch_count = 0;

  // When set, the sender idles for a short random burst after some requests.
  bit          gaps_on = 1'b0;

  // Appends one character to the buffer image. When the buffer is full the
  // character is lost, and the overflow flag sticks until the string ends.
  function automatic void store_char(input logic [7:0] c);
    if (text_len < BUF_DEPTH) begin
      text_img[text_len] = c;
      text_len++;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  // Applies one character that is not part of an escape.
  function automatic void apply_char(input logic [7:0] c, input bit fin);
    int unsigned k;
    if (c == CH_CR) begin
      // Carriage return cuts the text back to just after the last newline.
      k = text_len;
      while (k > 0 && text_img[k - 1] != CH_LF) k--;
      text_len = k;
    end else if (c == CH_FF) begin
      // A form feed clears the text, except on the last character, where it
      // is kept as an ordinary character.
      if (fin) store_char(c);
      else text_len = 0;
    end else if (c == CH_BS) begin
      // Backspace on empty text does nothing. Right after a newline, or as
      // the first character of a string, it is kept instead of deleting.
      if (text_len != 0) begin
        if (got_first && last_raw != CH_LF) text_len--;
        else store_char(c);
      end
    end else begin
      store_char(c);
    end
  endfunction

  // Folds one accepted request into the image and, on the last character of
  // a string, queues the whole edited text as the results to come.
  function automatic void edit_and_emit(input in_req_t req);
    out_res_t    r;
    int unsigned k;
    if (esc_wait) begin
      // A pending escape is resolved whatever the register says now.
      esc_wait = 1'b0;
      if (req.char_in == CH_BSLASH) begin
        store_char(CH_BSLASH);
      end else if (req.char_in == CH_N) begin
        store_char(CH_LF);
      end else begin
        store_char(CH_BSLASH);
        apply_char(req.char_in, req.final_char);
      end
    end else if (esc_on && req.char_in == CH_BSLASH && !req.final_char) begin
      esc_wait = 1'b1;
    end else begin
      apply_char(req.char_in, req.final_char);
    end
    last_raw  = req.char_in;
    got_first = 1'b1;

    if (req.final_char) begin
      if (text_len == 0) begin
        r.char_out   = 8'h00;
        r.run_end    = 1'b1;
        r.text_empty = 1'b1;
        r.overflowed = dropped;
        expected_text.push_back(r);
      end else begin
        for (k = 0; k < text_len; k++) begin
          r.char_out   = text_img[k];
          r.run_end    = (k + 1 == text_len);
          r.text_empty = 1'b0;
          r.overflowed = dropped;
          expected_text.push_back(r);
        end
      end
      // A new string starts from a clean state; the register keeps its value.
      text_len  = 0;
      esc_wait  = 1'b0;
      last_raw  = 8'h00;
      got_first = 1'b0;
      dropped   = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("ERROR at %0t ns: %s, expected %0h, got %0h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // Results are sampled on the falling edge, away from the rising edge
  // where the editor changes them. Each one is checked against the oldest
  // expected character.
  always @(negedge clk) begin
    out_res_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (expected_text.size() == 0) begin
        report_mismatch("result with nothing expected", 0, out_data);
      end else begin
        want = expected_text.pop_front();
        if (out_data.char_out !== want.char_out)
          report_mismatch("char_out", want.char_out, out_data.char_out);
        if (out_data.run_end !== want.run_end)
          report_mismatch("run_end", want.run_end, out_data.run_end);
        if (out_data.text_empty !== want.text_empty)
          report_mismatch("text_empty", want.text_empty, out_data.text_empty);
        if (out_data.overflowed !== want.overflowed)
          report_mismatch("overflowed", want.overflowed, out_data.overflowed);
      end
    end
  end

  // Lowers start and lets the given number of cycles pass. While idle the
  // request lines carry junk, which the editor must ignore.
  task automatic pause_sender(input int unsigned cycles);
    start   <= 1'b0;
    in_data <= in_req_t'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Offers one character and returns at the edge where it is taken. Start
  // stays high on return so that the next request can follow back to back;
  // whoever stops sending lowers it in that same step.
  task automatic send_char(input logic [7:0] c, input bit fin);
    in_req_t req;
    bit      taken;
    req.char_in    = c;
    req.final_char = fin;
    start   <= 1'b1;
    in_data <= req;
    taken = 1'b0;
    while (!taken) begin
      // Busy only moves on rising edges, so its value at the falling edge is
      // the one that the next rising edge sees.
      @(negedge clk);
      taken = (busy === 1'b0);
      @(posedge clk);
    end
    edit_and_emit(req);
    if (gaps_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 6));
  endtask

  // Holds off until every expected result has come, then lets the editor
  // finish any request that produces no result.
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the escape enable register, always from an idle editor.
  task automatic write_escapes(input bit en);
    bit taken;
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (cfg_ready === 1'b1);
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    esc_on = en;
  endtask

  // Random content weighted toward the characters that the editor treats
  // specially, so that escapes, cuts and deletions happen often.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 11))
      0:       return CH_BSLASH;
      1:       return CH_N;
      2:       return CH_CR;
      3:       return CH_LF;
      4:       return CH_FF;
      5:       return CH_BS;
      6:       return CH_BSLASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A carriage return alone and a backspace alone both leave nothing, so
  // each string comes back as a single empty result.
  task automatic test_empty_results();
    send_char(CH_CR, 1'b1);
    send_char(CH_BS, 1'b1);
  endtask

  // The zero byte and the all-ones byte are ordinary characters.
  task automatic test_byte_extremes();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  // Double backslash, backslash n, a broken escape that keeps its backslash
  // and hands the next character on, and a backslash that ends the string.
  task automatic test_escapes();
    send_char(CH_BSLASH, 1'b0);
    send_char(CH_BSLASH, 1'b0);
    send_char(CH_BSLASH, 1'b0);
    send_char(CH_N, 1'b0);
    send_char(CH_BSLASH, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(CH_BSLASH, 1'b1);
  endtask

  // Backspace kept right after a newline, backspace deleting, carriage
  // return cutting back to the newline, a form feed clearing the text, and
  // a form feed kept because it ends the string.
  task automatic test_control_chars();
    send_char(8'h61, 1'b0);
    send_char(CH_LF, 1'b0);
    send_char(CH_BS, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(CH_BS, 1'b0);
    send_char(CH_CR, 1'b0);
    send_char(CH_FF, 1'b0);
    send_char(8'h63, 1'b0);
    send_char(CH_FF, 1'b1);
  endtask

  // With escapes off a backslash is plain text. An escape left pending when
  // the register is cleared is still resolved by the next character.
  task automatic test_escape_register();
    write_escapes(1'b0);
    send_char(CH_BSLASH, 1'b0);
    send_char(CH_BSLASH, 1'b1);
    write_escapes(1'b1);
    send_char(CH_BSLASH, 1'b0);
    write_escapes(1'b0);
    send_char(CH_N, 1'b1);
  endtask

  // More characters than the buffer holds: the surplus is dropped and every
  // result of the string carries the overflow flag.
  task automatic test_full_buffer();
    logic [7:0] c;
    for (int i = 0; i < BUF_DEPTH + 6; i++) begin
      c = 8'($urandom_range(8'h20, 8'h7E));
      if (c == CH_BSLASH) c = 8'h7C;
      send_char(c, 1'b0);
    end
    send_char(8'h5A, 1'b1);
  endtask

  // Whole strings of random content, mostly short, now and then long enough
  // to fill the buffer, until the budget of requests is spent.
  task automatic test_random_strings(input int unsigned budget, input bit with_gaps);
    int unsigned sent;
    int unsigned len;
    gaps_on = with_gaps;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 11) == 0) len = $urandom_range(50, 70);
      else len = $urandom_range(1, 12);
      for (int unsigned i = 0; i < len; i++) send_char(pick_char(), i + 1 == len);
      sent += len;
    end
    gaps_on = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_results();
    test_byte_extremes();
    test_escapes();
    test_control_chars();
    test_escape_register();
    test_random_strings(15, 1'b1);
    write_escapes(1'b1);
    test_full_buffer();
    test_random_strings(15, 1'b1);
    // The last part runs with the sender never idling.
    test_random_strings(15, 1'b0);

    start <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_text.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // A hung handshake ends the run here, far beyond the slowest correct run.
  initial begin
    #3ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
hdl/tcle_pkg.sv
hdl/tcle_front.sv
hdl/tcle_queue.sv
hdl/tcle_back.sv
hdl/text_control_char_line_editor.sv
tb/text_control_char_line_editor_tb.sv
